/* rtl/core/crcdf_pkg.sv */
// crcdf_pkg: shared types, constants and the CRC-16/CCITT-FALSE byte update
// for the frame deframer. No dependencies.
`timescale 1ns / 1ps

package crcdf_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 7;
    localparam int unsigned IDX_OUT_W  = 6;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 1'b1;

    localparam logic [BYTE_W-1:0] START_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] START_SECOND_RST = 8'h5A;
    localparam logic [LEN_W-1:0]  LEN_SAT          = 7'd127;

    // controller -> datapath
    typedef struct packed {
        logic crc_init;
        logic crc_upd;
        logic hdr_cap;
        logic pay_wr;
        logic crc_lo_cap;
        logic emit_start;
        logic emit_load;
        logic empty_load;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic match_first;
        logic match_second;
        logic hdr_last;
        logic hdr_ok;
        logic len_zero;
        logic pay_done;
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } t_dp_status;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((crc & CRC_MSB) != 16'h0000) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/core/crcdf_ctrl.sv */
// crcdf_ctrl: parse and emit state machine of the frame deframer.
// Depends on crcdf_pkg; drives commands into crcdf_dp.
`timescale 1ns / 1ps

module crcdf_ctrl
    import crcdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] ST_HUNT0   = 3'd0;
    localparam logic [2:0] ST_HUNT1   = 3'd1;
    localparam logic [2:0] ST_HEADER  = 3'd2;
    localparam logic [2:0] ST_PAYLOAD = 3'd3;
    localparam logic [2:0] ST_CRC0    = 3'd4;
    localparam logic [2:0] ST_CRC1    = 3'd5;
    localparam logic [2:0] ST_EMIT_RD = 3'd6;
    localparam logic [2:0] ST_EMIT_WR = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       s_acc;

    always_comb begin
        unique case (r_state)
            ST_CRC1:                o_s_tready = i_sts.out_free;
            ST_EMIT_RD, ST_EMIT_WR: o_s_tready = 1'b0;
            default:                o_s_tready = 1'b1;
        endcase
    end

    assign s_acc = i_s_tvalid & o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HUNT0: begin
                if (s_acc && i_sts.match_first) n_state = ST_HUNT1;
            end
            ST_HUNT1: begin
                if (s_acc) begin
                    if (i_sts.match_second) begin
                        n_state        = ST_HEADER;
                        o_cmd.crc_init = 1'b1;
                    end else if (!i_sts.match_first) begin
                        n_state = ST_HUNT0;
                    end
                end
            end
            ST_HEADER: begin
                if (s_acc) begin
                    o_cmd.crc_upd = 1'b1;
                    o_cmd.hdr_cap = 1'b1;
                    if (i_sts.hdr_last) begin
                        if (!i_sts.hdr_ok)        n_state = ST_HUNT0;
                        else if (i_sts.len_zero)  n_state = ST_CRC0;
                        else                      n_state = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                if (s_acc) begin
                    o_cmd.crc_upd = 1'b1;
                    o_cmd.pay_wr  = 1'b1;
                    if (i_sts.pay_done) n_state = ST_CRC0;
                end
            end
            ST_CRC0: begin
                if (s_acc) begin
                    o_cmd.crc_lo_cap = 1'b1;
                    n_state          = ST_CRC1;
                end
            end
            ST_CRC1: begin
                if (s_acc) begin
                    n_state = ST_HUNT0;
                    if (i_sts.crc_ok) begin
                        if (i_sts.len_zero) begin
                            o_cmd.empty_load = 1'b1;
                        end else begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = ST_EMIT_RD;
                        end
                    end
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state         = i_sts.emit_last ? ST_HUNT0 : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_HUNT0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT0;
        end else begin
            r_state <= n_state;
        end
    end

    a_crc1_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRC1 && s_acc) |-> i_sts.out_free)
        else $error("frame end accepted while output slot busy");

    a_pay_to_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.pay_wr && i_sts.pay_done) |=> (r_state == ST_CRC0))
        else $error("payload end did not move to crc capture");

    a_emit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_load && i_sts.emit_last) |=> (r_state == ST_HUNT0))
        else $error("emission run did not end on its last result");

    a_no_rx_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT_RD || r_state == ST_EMIT_WR) |-> !o_cmd.crc_upd && !o_cmd.pay_wr)
        else $error("receive command during emission");

endmodule

/* rtl/core/crcdf_dp.sv */
// crcdf_dp: datapath of the frame deframer: marker registers, header fields,
// running CRC, payload memory and output register. Depends on crcdf_pkg.
`timescale 1ns / 1ps

module crcdf_dp
    import crcdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0]     i_cfg_data,
    input  logic [BYTE_W-1:0]     i_rx_byte,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_sts,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser,
    output logic                  o_m_tlast
);

    localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    logic [BYTE_W-1:0] r_start_first;
    logic [BYTE_W-1:0] r_start_second;
    logic [1:0]        r_hdr_cnt;
    logic [BYTE_W-1:0] r_held_cmd;
    logic [BYTE_W-1:0] r_held_flags;
    logic [LEN_W-1:0]  r_held_len;
    logic [CNT_W-1:0]  r_pay_cnt;
    logic [IDX_W-1:0]  r_emit_idx;
    logic [15:0]       r_crc;
    logic [BYTE_W-1:0] r_crc_lo;
    logic [BYTE_W-1:0] r_mem [MAX_PAYLOAD];
    logic [BYTE_W-1:0] r_rdata;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_cmd;
    logic [BYTE_W-1:0] r_out_flags;
    logic [LEN_W-1:0]  r_out_len;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_has;
    logic              r_out_last;

    logic              s_out_free;

    assign s_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        o_sts.match_first  = (i_rx_byte == r_start_first);
        o_sts.match_second = (i_rx_byte == r_start_second);
        o_sts.hdr_last     = (r_hdr_cnt == 2'd3);
        o_sts.hdr_ok       = (i_rx_byte == '0) && (r_held_len <= MAX_LEN);
        o_sts.len_zero     = (r_held_len == '0);
        o_sts.pay_done     = (LEN_W'(r_pay_cnt) + LEN_W'(1)) >= r_held_len;
        o_sts.crc_ok       = ({i_rx_byte, r_crc_lo} == r_crc);
        o_sts.emit_last    = (LEN_W'(r_emit_idx) + LEN_W'(1)) == r_held_len;
        o_sts.out_free     = s_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_first  <= START_FIRST_RST;
            r_start_second <= START_SECOND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_FIRST:  r_start_first  <= i_cfg_data;
                CFG_START_SECOND: r_start_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt    <= '0;
            r_held_cmd   <= '0;
            r_held_flags <= '0;
            r_held_len   <= '0;
            r_pay_cnt    <= '0;
            r_emit_idx   <= '0;
            r_crc        <= CRC_INIT;
            r_crc_lo     <= '0;
        end else begin
            if (i_cmd.crc_init) begin
                r_crc     <= CRC_INIT;
                r_hdr_cnt <= '0;
                r_pay_cnt <= '0;
            end
            if (i_cmd.crc_upd) r_crc <= crc16_byte(r_crc, i_rx_byte);
            if (i_cmd.hdr_cap) begin
                r_hdr_cnt <= r_hdr_cnt + 2'd1;
                case (r_hdr_cnt)
                    2'd0: r_held_cmd   <= i_rx_byte;
                    2'd1: r_held_flags <= i_rx_byte;
                    2'd2: r_held_len   <= i_rx_byte[7] ? LEN_SAT : i_rx_byte[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.pay_wr)     r_pay_cnt  <= r_pay_cnt + CNT_W'(1);
            if (i_cmd.crc_lo_cap) r_crc_lo   <= i_rx_byte;
            if (i_cmd.emit_start) r_emit_idx <= '0;
            if (i_cmd.emit_load)  r_emit_idx <= r_emit_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_wr) r_mem[r_pay_cnt[IDX_W-1:0]] <= i_rx_byte;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_emit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load || i_cmd.empty_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_cmd   <= r_held_cmd;
            r_out_flags <= r_held_flags;
            r_out_len   <= r_held_len;
            r_out_idx   <= IDX_OUT_W'(r_emit_idx);
            r_out_byte  <= r_rdata;
            r_out_has   <= 1'b1;
            r_out_last  <= o_sts.emit_last;
        end else if (i_cmd.empty_load) begin
            r_out_cmd   <= r_held_cmd;
            r_out_flags <= r_held_flags;
            r_out_len   <= '0;
            r_out_idx   <= '0;
            r_out_byte  <= '0;
            r_out_has   <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_byte, r_out_idx, r_out_len, r_out_flags, r_out_cmd};
    assign o_m_tuser  = r_out_has;
    assign o_m_tlast  = r_out_last;

    a_pay_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_cnt <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond store depth");

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_load || i_cmd.empty_load) |-> s_out_free)
        else $error("output register overwritten before transfer");

    a_load_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.emit_load && i_cmd.empty_load))
        else $error("payload and empty result loaded together");

endmodule

/* rtl/core/crc16_frame_deframer_unit.sv */
// Byte-serial receiver for marker + header + payload + CRC-16/CCITT-FALSE
// frames. A received byte is taken every cycle while a frame is parsed. The
// second CRC byte is the exception: it waits until the output register is
// free. After the second CRC byte of a good frame the payload is read back
// from the payload memory one result at a time (a read state registers the
// read data, then a write state loads it into the output register).
// Output backpressure holds the write state. No byte is taken during that
// run. A zero-length frame loads its one result into the output register at
// the edge that takes its last CRC byte. A bad marker, an oversize length or
// a CRC mismatch gives no result, and the parser returns to hunting.
// Depends on crcdf_pkg, crcdf_ctrl and crcdf_dp.
`timescale 1ns / 1ps

module crc16_frame_deframer_unit
    import crcdf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [BYTE_W-1:0]     i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [BYTE_W-1:0]     i_s_tdata,   // [7:0] rx_byte
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] command, [15:8] frame_flags, [22:16] frame_length,
    // [28:23] byte_index, [36:29] payload_byte, [39:37] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tuser,   // [0] has_payload
    output logic                  o_m_tlast
);

    t_dp_cmd    s_cmd;
    t_dp_status s_sts;

    assign o_cfg_ready = 1'b1;

    crcdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    crcdf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (i_s_tdata),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
